>>> src/srpe_pkg.sv
package srpe_pkg;

    // Width of the sample fields on the ports.
    localparam int IN_W  = 24;
    localparam int OUT_W = 25;

    // Operation codes of an input item.
    localparam logic [1:0] OP_START_REC  = 2'd0;
    localparam logic [1:0] OP_RECORD     = 2'd1;
    localparam logic [1:0] OP_START_PLAY = 2'd2;
    localparam logic [1:0] OP_PLAY_TICK  = 2'd3;

    // Run modes, also reported as status.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_REC  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;

    // Latched playback speed.
    localparam logic [1:0] SPEED_NORMAL = 2'd0;
    localparam logic [1:0] SPEED_REPEAT = 2'd1;
    localparam logic [1:0] SPEED_SKIP   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ECHO_SELECT = 1'b0;
    localparam logic CFG_SPEED_MODE  = 1'b1;

    // Echo delays in samples.
    localparam int          DELAY_W     = 14;
    localparam logic [13:0] DELAY_NONE  = 14'd0;
    localparam logic [13:0] DELAY_SHORT = 14'd2400;
    localparam logic [13:0] DELAY_LONG  = 14'd13200;

    typedef logic signed [OUT_W-1:0] out_sample_t;

endpackage

>>> src/stereo_record_playback_echo_top.sv
// Stereo recorder and player with optional echo. One item is accepted per
// clock cycle while the result path does not stall. The control state and
// the two reads of the sample memory (the current entry and the echo entry)
// are registered in the first stage, and the echo sum in the result register.
// The sample memory has one write port and two registered read ports, which
// is what lets a play tick fetch both entries together. The memory
// is not cleared; playback is meant to follow a completed recording.
module stereo_record_playback_echo_top
    import srpe_pkg::*;
#(
    parameter int DEPTH       = 131072,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_op,
    input  logic signed [IN_W-1:0]  s_left_in,
    input  logic signed [IN_W-1:0]  s_right_in,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic                    m_sample_valid,
    output logic                    m_last,
    output logic signed [OUT_W-1:0] m_left_out,
    output logic signed [OUT_W-1:0] m_right_out,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_addr,
    input  logic [1:0]              cfg_data
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = ADDR_W + 1;
    localparam int STORE_W = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;

    // Configuration registers.
    logic [1:0] echo_select_reg;
    logic [1:0] speed_mode_reg;

    // Control state.
    logic [1:0]         mode_reg, mode_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               phase_reg, phase_next;
    logic [1:0]         speed_reg, speed_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;

    logic               accept;
    logic               wr_en;
    logic               res_valid;
    logic               res_last;
    logic               echo_en;
    logic [IDX_W-1:0]   echo_idx;
    logic [IDX_W-1:0]   idx_inc;
    logic [1:0]         step;
    logic               idx_in_range;

    // Sample memories.
    logic [STORE_W-1:0] left_mem  [DEPTH];
    logic [STORE_W-1:0] right_mem [DEPTH];

    // First pipeline stage: read data and control of the item.
    logic               p1_valid_reg;
    logic [1:0]         p1_status_reg;
    logic               p1_sample_reg;
    logic               p1_last_reg;
    logic               p1_echo_reg;
    logic [STORE_W-1:0] rd_left_reg;
    logic [STORE_W-1:0] rd_right_reg;
    logic [STORE_W-1:0] rd_left_echo_reg;
    logic [STORE_W-1:0] rd_right_echo_reg;
    logic               p1_adv;

    // Result register.
    logic               m_valid_reg;
    logic [1:0]         m_status_reg;
    logic               m_sample_reg;
    logic               m_last_reg;
    out_sample_t        m_left_reg;
    out_sample_t        m_right_reg;

    out_sample_t        left_sum;
    out_sample_t        right_sum;

    function automatic out_sample_t ext_sample(input logic [STORE_W-1:0] v);
        return out_sample_t'({{(OUT_W-STORE_W){v[STORE_W-1]}}, v});
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_select_reg <= 2'd0;
            speed_mode_reg  <= 2'd0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_ECHO_SELECT: echo_select_reg <= cfg_data;
                CFG_SPEED_MODE:  speed_mode_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign p1_adv  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || p1_adv;
    assign accept  = s_valid && s_ready;

    assign idx_in_range = idx_reg < IDX_W'(DEPTH);
    assign echo_idx     = idx_reg - IDX_W'(delay_reg);
    assign idx_inc      = idx_reg + IDX_W'(step);

    always_comb begin
        if (speed_reg == SPEED_SKIP) begin
            step = 2'd2;
        end else if (speed_reg == SPEED_REPEAT) begin
            step = {1'b0, phase_reg};
        end else begin
            step = 2'd1;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        speed_next = speed_reg;
        delay_next = delay_reg;
        wr_en      = 1'b0;
        res_valid  = 1'b0;
        res_last   = 1'b0;
        echo_en    = 1'b0;
        unique case (s_op)
            OP_START_REC: begin
                idx_next  = '0;
                mode_next = MODE_REC;
            end
            OP_RECORD: begin
                if (mode_reg == MODE_REC && idx_in_range) begin
                    wr_en    = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_next >= IDX_W'(DEPTH)) begin
                        mode_next = MODE_IDLE;
                        res_last  = 1'b1;
                    end
                end
            end
            OP_START_PLAY: begin
                idx_next   = '0;
                phase_next = 1'b1;
                if (speed_mode_reg[0]) begin
                    speed_next = SPEED_REPEAT;
                end else if (speed_mode_reg[1]) begin
                    speed_next = SPEED_SKIP;
                end else begin
                    speed_next = SPEED_NORMAL;
                end
                if (echo_select_reg[1]) begin
                    delay_next = DELAY_LONG;
                end else if (echo_select_reg[0]) begin
                    delay_next = DELAY_SHORT;
                end else begin
                    delay_next = DELAY_NONE;
                end
                mode_next = MODE_PLAY;
            end
            OP_PLAY_TICK: begin
                if (mode_reg == MODE_PLAY && idx_in_range) begin
                    res_valid  = 1'b1;
                    echo_en    = (delay_reg != DELAY_NONE) && (idx_reg >= IDX_W'(delay_reg));
                    idx_next   = idx_inc;
                    phase_next = !phase_reg;
                    if (idx_inc >= IDX_W'(DEPTH)) begin
                        mode_next = MODE_IDLE;
                        res_last  = 1'b1;
                    end
                end else if (mode_reg == MODE_PLAY) begin
                    mode_next = MODE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            idx_reg   <= '0;
            phase_reg <= 1'b1;
            speed_reg <= SPEED_NORMAL;
            delay_reg <= DELAY_NONE;
        end else if (accept) begin
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            speed_reg <= speed_next;
            delay_reg <= delay_next;
        end
    end

    // Reads for an item that is not a play tick fetch don't-care data that
    // the result stage masks out.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (wr_en) begin
                left_mem[idx_reg[ADDR_W-1:0]]  <= s_left_in[STORE_W-1:0];
                right_mem[idx_reg[ADDR_W-1:0]] <= s_right_in[STORE_W-1:0];
            end
            rd_left_reg       <= left_mem[idx_reg[ADDR_W-1:0]];
            rd_right_reg      <= right_mem[idx_reg[ADDR_W-1:0]];
            rd_left_echo_reg  <= left_mem[echo_idx[ADDR_W-1:0]];
            rd_right_echo_reg <= right_mem[echo_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_status_reg <= mode_next;
            p1_sample_reg <= res_valid;
            p1_last_reg   <= res_last;
            p1_echo_reg   <= echo_en;
        end
    end

    always_comb begin
        left_sum  = ext_sample(rd_left_reg);
        right_sum = ext_sample(rd_right_reg);
        if (p1_echo_reg) begin
            left_sum  = left_sum + (ext_sample(rd_left_echo_reg) >>> 2);
            right_sum = right_sum + (ext_sample(rd_right_echo_reg) >>> 2);
        end
        if (!p1_sample_reg) begin
            left_sum  = '0;
            right_sum = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_status_reg <= p1_status_reg;
            m_sample_reg <= p1_sample_reg;
            m_last_reg   <= p1_last_reg;
            m_left_reg   <= left_sum;
            m_right_reg  <= right_sum;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_sample_valid = m_sample_reg;
    assign m_last         = m_last_reg;
    assign m_left_out     = m_left_reg;
    assign m_right_out    = m_right_reg;

endmodule

>>> src/srpe_checker.sv
module srpe_checker
    import srpe_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [1:0]              m_status,
    input logic                    m_sample_valid,
    input logic                    m_last,
    input logic signed [OUT_W-1:0] m_left_out,
    input logic signed [OUT_W-1:0] m_right_out
);

    // An item without a playback sample carries silent outputs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_sample_valid) |-> (m_left_out == '0 && m_right_out == '0))
        else $error("outputs not zero on an item without a sample");

    // The final recorded or played sample always leaves the block idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> (m_status == MODE_IDLE))
        else $error("last flag with a status other than idle");

    // A playback sample is never reported while recording.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sample_valid) |-> (m_status != MODE_REC))
        else $error("playback sample with recording status");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_left_out) && $stable(m_right_out)
            && $stable(m_status) && $stable(m_last)))
        else $error("stalled result changed");

endmodule

bind stereo_record_playback_echo_top srpe_checker u_srpe_checker (.*);

>>> sim/stereo_record_playback_echo_top_tb.sv
`timescale 1ns / 100ps

module stereo_record_playback_echo_top_tb;
    import srpe_pkg::*;

    // The memory size used in this bench.
    localparam int DEPTH       = 16384;
    localparam int TB_ADDR_W   = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int IDLE_PCT    = 38;

    localparam logic signed [IN_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [IN_W-1:0] S_MIN = 24'sh800000;

    typedef struct packed {
        logic [1:0]              status;
        logic                    sample_valid;
        logic                    last;
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
    } play_result_t;

    typedef struct {
        logic [1:0]             op;
        logic signed [IN_W-1:0] left_s;
        logic signed [IN_W-1:0] right_s;
        bit                     typed;
        play_result_t           want;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_op       = OP_START_REC;
    logic signed [IN_W-1:0]  s_left_in  = '0;
    logic signed [IN_W-1:0]  s_right_in = '0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_status;
    logic                    m_sample_valid;
    logic                    m_last;
    logic signed [OUT_W-1:0] m_left_out;
    logic signed [OUT_W-1:0] m_right_out;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic                    cfg_addr  = CFG_ECHO_SELECT;
    logic [1:0]              cfg_data  = 2'd0;

    bit gaps_on = 1'b1;
    int mismatches = 0;
    int results_seen = 0;
    int cycle_count = 0;

    play_result_t expected_q[$];
    play_result_t head_exp;

    // Player state as the block should hold it.
    logic signed [IN_W-1:0] left_mem  [DEPTH];
    logic signed [IN_W-1:0] right_mem [DEPTH];
    int unsigned play_idx   = 0;
    int unsigned held_delay = 0;
    int unsigned filled     = 0;
    bit          rep_phase  = 1'b1;
    logic [1:0]  run_state  = MODE_IDLE;
    logic [1:0]  held_speed = SPEED_NORMAL;
    logic [1:0]  echo_cfg   = 2'd0;
    logic [1:0]  speed_cfg  = 2'd0;

    // Directed items; the expected result is typed in where it is obvious.
    dir_row_t plan [21] = '{
        '{OP_PLAY_TICK,  '0,    '0,    1'b1, '{MODE_IDLE, 1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_RECORD,     S_MAX, S_MIN, 1'b1, '{MODE_IDLE, 1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_START_PLAY, S_MIN, S_MAX, 1'b1, '{MODE_PLAY, 1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_START_REC,  S_MAX, S_MAX, 1'b1, '{MODE_REC,  1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_RECORD,     S_MAX, S_MIN, 1'b1, '{MODE_REC,  1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_RECORD,     S_MIN, S_MAX, 1'b1, '{MODE_REC,  1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_RECORD,     '0,    '1,    1'b1, '{MODE_REC,  1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_RECORD,     '1,    '0,    1'b0, '0},
        '{OP_RECORD,     24'sh5A5A5A, 24'shA5A5A5, 1'b0, '0},
        '{OP_START_PLAY, '0,    '0,    1'b1, '{MODE_PLAY, 1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_PLAY_TICK,  '0,    '0,    1'b1,
          '{MODE_PLAY, 1'b1, 1'b0, 25'sd8388607, -25'sd8388608}},
        '{OP_PLAY_TICK,  S_MAX, S_MIN, 1'b1,
          '{MODE_PLAY, 1'b1, 1'b0, -25'sd8388608, 25'sd8388607}},
        '{OP_PLAY_TICK,  '1,    '1,    1'b1, '{MODE_PLAY, 1'b1, 1'b0, 25'sd0, -25'sd1}},
        '{OP_START_REC,  '0,    '0,    1'b1, '{MODE_REC,  1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_RECORD,     24'sh123456, 24'shEDCBA9, 1'b0, '0},
        '{OP_START_PLAY, '0,    '0,    1'b1, '{MODE_PLAY, 1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_PLAY_TICK,  '0,    '0,    1'b0, '0},
        '{OP_PLAY_TICK,  S_MIN, S_MAX, 1'b0, '0},
        '{OP_RECORD,     S_MAX, S_MAX, 1'b1, '{MODE_PLAY, 1'b0, 1'b0, 25'sd0, 25'sd0}},
        '{OP_PLAY_TICK,  '0,    '0,    1'b0, '0},
        '{OP_START_PLAY, '0,    '0,    1'b1, '{MODE_PLAY, 1'b0, 1'b0, 25'sd0, 25'sd0}}
    };

    stereo_record_playback_echo_top #(
        .DEPTH (DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_left_in      (s_left_in),
        .s_right_in     (s_right_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_sample_valid (m_sample_valid),
        .m_last         (m_last),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic play_result_t step_player(input logic [1:0] op,
                                                 input logic signed [IN_W-1:0] l_in,
                                                 input logic signed [IN_W-1:0] r_in);
        play_result_t res;
        int unsigned  idx;
        int unsigned  e_idx;
        res = '0;
        case (op)
            OP_START_REC: begin
                play_idx  = 0;
                run_state = MODE_REC;
            end
            OP_RECORD: begin
                if (run_state == MODE_REC && play_idx < DEPTH) begin
                    left_mem[play_idx[TB_ADDR_W-1:0]]  = l_in;
                    right_mem[play_idx[TB_ADDR_W-1:0]] = r_in;
                    play_idx++;
                    if (play_idx > filled)
                        filled = play_idx;
                    if (play_idx >= DEPTH) begin
                        run_state = MODE_IDLE;
                        res.last  = 1'b1;
                    end
                end
            end
            OP_START_PLAY: begin
                play_idx   = 0;
                rep_phase  = 1'b1;
                held_speed = speed_cfg[0] ? SPEED_REPEAT
                           : (speed_cfg[1] ? SPEED_SKIP : SPEED_NORMAL);
                held_delay = 32'(echo_cfg[1] ? DELAY_LONG
                               : (echo_cfg[0] ? DELAY_SHORT : DELAY_NONE));
                run_state  = MODE_PLAY;
            end
            default: begin
                if (run_state == MODE_PLAY && play_idx < DEPTH) begin
                    idx           = play_idx;
                    res.left_out  = OUT_W'(left_mem[idx[TB_ADDR_W-1:0]]);
                    res.right_out = OUT_W'(right_mem[idx[TB_ADDR_W-1:0]]);
                    if (held_delay != 0 && idx >= held_delay) begin
                        e_idx         = idx - held_delay;
                        res.left_out  = res.left_out
                                      + (OUT_W'(left_mem[e_idx[TB_ADDR_W-1:0]]) >>> 2);
                        res.right_out = res.right_out
                                      + (OUT_W'(right_mem[e_idx[TB_ADDR_W-1:0]]) >>> 2);
                    end
                    res.sample_valid = 1'b1;
                    case (held_speed)
                        SPEED_SKIP:   play_idx = idx + 2;
                        SPEED_REPEAT: play_idx = idx + 32'(rep_phase);
                        default:      play_idx = idx + 1;
                    endcase
                    rep_phase = ~rep_phase;
                    if (play_idx >= DEPTH) begin
                        run_state = MODE_IDLE;
                        res.last  = 1'b1;
                    end
                end else if (run_state == MODE_PLAY) begin
                    run_state = MODE_IDLE;
                end
            end
        endcase
        res.status = run_state;
        return res;
    endfunction

    // A play tick must never reach a memory entry that was never recorded.
    function automatic bit tick_ok();
        return run_state != MODE_PLAY || play_idx < filled;
    endfunction

    function automatic logic signed [IN_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic signed [OUT_W-1:0] got,
                             input logic signed [OUT_W-1:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s: got %0d expected %0d",
                                 results_seen, name, got, want));
    endtask

    // Called at a falling edge. Returns at the falling edge after acceptance, with
    // valid still high, so a following item can keep valid up without a dip.
    task automatic send_item(input logic [1:0] op, input logic signed [IN_W-1:0] l_in,
                             input logic signed [IN_W-1:0] r_in,
                             input bit has_want = 1'b0, input play_result_t want = '0);
        play_result_t pred;
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_left_in  <= l_in;
        s_right_in <= r_in;
        do @(posedge aclk); while (!s_ready);
        pred = step_player(op, l_in, r_in);
        expected_q.push_back(has_want ? want : pred);
        @(negedge aclk);
    endtask

    task automatic send_noise();
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        if (op == OP_PLAY_TICK && !tick_ok())
            op = OP_START_REC;
        send_item(op, rand_sample(), rand_sample());
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] echo, input logic [1:0] speed);
        cfg_valid <= 1'b1;
        cfg_addr  <= CFG_ECHO_SELECT;
        cfg_data  <= echo;
        do @(posedge aclk); while (!cfg_ready);
        echo_cfg = echo;
        @(negedge aclk);
        cfg_addr <= CFG_SPEED_MODE;
        cfg_data <= speed;
        do @(posedge aclk); while (!cfg_ready);
        speed_cfg = speed;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One recording followed by one playback. A retune rewrites the settings
    // halfway through playback, which must not touch the latched values.
    task automatic run_take(input int rec_len, input int play_len, input logic [1:0] echo,
                            input logic [1:0] speed, input bit retune, input bit noisy);
        int n;
        wait_idle();
        write_cfg(echo, speed);
        send_item(OP_START_REC, rand_sample(), rand_sample());
        for (n = 0; n < rec_len; n++) begin
            if (noisy && $urandom_range(0, 99) < 2)
                send_noise();
            send_item(OP_RECORD, rand_sample(), rand_sample());
        end
        send_item(OP_START_PLAY, rand_sample(), rand_sample());
        for (n = 0; n < play_len && run_state == MODE_PLAY; n++) begin
            if (retune && n == play_len / 2) begin
                wait_idle();
                write_cfg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            end
            if (noisy && $urandom_range(0, 99) < 2)
                send_noise();
            if (!tick_ok())
                break;
            send_item(OP_PLAY_TICK, rand_sample(), rand_sample());
        end
        if (noisy) begin
            repeat ($urandom_range(0, 3))
                send_noise();
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                head_exp = expected_q.pop_front();
                cmp_field("status", OUT_W'(m_status), OUT_W'(head_exp.status));
                cmp_field("sample_valid", OUT_W'(m_sample_valid),
                          OUT_W'(head_exp.sample_valid));
                cmp_field("last", OUT_W'(m_last), OUT_W'(head_exp.last));
                cmp_field("left_out", m_left_out, head_exp.left_out);
                cmp_field("right_out", m_right_out, head_exp.right_out);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("FAIL stereo_record_playback_echo_top");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < $size(plan); k++)
            send_item(plan[k].op, plan[k].left_s, plan[k].right_s, plan[k].typed, plan[k].want);

        // A long take in repeat mode with neither side ever idle.
        gaps_on = 1'b0;
        run_take(120, 240, 2'd2, 2'd1, 1'b0, 1'b0);
        gaps_on = 1'b1;

        // Playbacks in skip mode and, with both speed bits set, in repeat mode; the
        // older recording stays behind the short new one, so all of it is readable.
        run_take($urandom_range(1, 30), 240, 2'd1, 2'd2, 1'b1, 1'b0);
        run_take($urandom_range(1, 30), 120, 2'd3, 2'd3, 1'b0, 1'b0);

        for (k = 0; k < 13; k++) begin
            run_take($urandom_range(1, 40),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(0, 50),
                     2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     $urandom_range(0, 3) == 0, 1'b1);
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS stereo_record_playback_echo_top");
        else
            $display("FAIL stereo_record_playback_echo_top");
        $finish;
    end

endmodule

>>> filelist.f
src/srpe_pkg.sv
src/stereo_record_playback_echo_top.sv
src/srpe_checker.sv
sim/stereo_record_playback_echo_top_tb.sv
